FILE: rtl/local_alignment_clone_finder_defines.svh
// Assertion helpers used by the clone finder module.
`ifndef LOCAL_ALIGNMENT_CLONE_FINDER_DEFINES_SVH
`define LOCAL_ALIGNMENT_CLONE_FINDER_DEFINES_SVH

// Overlapping implication, sampled on the block clock outside reset.
`define LACF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the block clock outside reset.
`define LACF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lacf_pkg.sv
package lacf_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned SYM_W   = 10;
  localparam int unsigned SCORE_W = 14;
  localparam int unsigned PEN_W   = 6;
  localparam int unsigned SEP_W   = 4;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned DIR_W   = 3;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 14;

  localparam logic [SCORE_W-1:0] SCORE_MAX = 14'd16383;

  // Input operations.
  localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN      = 2'd2;

  // Direction codes; the top bit is the clone mark.
  localparam logic [1:0] DIR_END  = 2'd0;
  localparam logic [1:0] DIR_LEFT = 2'd1;
  localparam logic [1:0] DIR_UP   = 2'd2;
  localparam logic [1:0] DIR_DIAG = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MATCH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEP      = 3'd4;

  // Configuration reset values.
  localparam logic [PEN_W-1:0]   RST_MATCH    = 6'd10;
  localparam logic [PEN_W-1:0]   RST_MISMATCH = 6'd10;
  localparam logic [PEN_W-1:0]   RST_GAP      = 6'd18;
  localparam logic [SCORE_W-1:0] RST_MIN      = 14'd12;
  localparam logic [SEP_W-1:0]   RST_SEP      = 4'd2;

  typedef struct packed {
    logic [PEN_W-1:0]   match_score;
    logic [PEN_W-1:0]   mismatch_penalty;
    logic [PEN_W-1:0]   gap_penalty;
    logic [SCORE_W-1:0] min_clone_score;
    logic [SEP_W-1:0]   clone_separation;
  } cfg_t;

  typedef enum logic [10:0] {
    S_IDLE       = 11'b000_0000_0001,
    S_FILL_RD    = 11'b000_0000_0010,
    S_FILL_CALC  = 11'b000_0000_0100,
    S_SCAN_RD    = 11'b000_0000_1000,
    S_SCAN_CHK   = 11'b000_0001_0000,
    S_WIN_RD     = 11'b000_0010_0000,
    S_WIN_CHK    = 11'b000_0100_0000,
    S_TRACE_RD   = 11'b000_1000_0000,
    S_TRACE_STEP = 11'b001_0000_0000,
    S_REPORT     = 11'b010_0000_0000,
    S_FINAL      = 11'b100_0000_0000
  } state_e;

endpackage

FILE: rtl/lacf_if.sv
// Input item channel.
interface lacf_in_if;
  logic                           valid;
  logic                           ready;
  logic [lacf_pkg::OP_W-1:0]      operation;
  logic [lacf_pkg::SYM_W-1:0]     symbol;

  modport source (output valid, operation, symbol, input ready);
  modport sink   (input valid, operation, symbol, output ready);
endinterface

// Result item channel.
interface lacf_out_if;
  logic                           valid;
  logic                           ready;
  logic                           is_clone;
  logic [lacf_pkg::IDX_W-1:0]     a_start;
  logic [lacf_pkg::IDX_W-1:0]     a_end;
  logic [lacf_pkg::IDX_W-1:0]     b_start;
  logic [lacf_pkg::IDX_W-1:0]     b_end;
  logic [lacf_pkg::SCORE_W-1:0]   score;
  logic                           overflow;
  logic                           last;

  modport source (output valid, is_clone, a_start, a_end, b_start, b_end, score, overflow,
                  last, input ready);
  modport sink   (input valid, is_clone, a_start, a_end, b_start, b_end, score, overflow,
                  last, output ready);
endinterface

FILE: rtl/local_alignment_clone_finder.sv
// Local alignment clone finder.
// Input items carry an operation and a symbol: append to sequence A, append to
// sequence B, or run. Appends give no result. A run fills the score and
// direction tables cell by cell, then scans every cell; a candidate also
// checks its window (up to (2*sep)^2 cells) and follows its trace-back. The
// fill goes through one cell scoring unit, and the whole run uses memories
// that each have one write port and one registered read port.
// The run emits one result item per reported clone and ends with a completion
// record carrying last, then clears both sequences. Input ready is held low
// from the run item until the completion record has been loaded.
// Results sit in an output register; if the receiver stalls, the sequencer
// waits on its next report until the register frees up.
// Reset sets the configuration registers to their defaults and empties both
// sequences; no memory clearing pass is needed. Configuration must be written
// through the write port only while the block is idle; the block does not enforce this.
`include "local_alignment_clone_finder_defines.svh"

module local_alignment_clone_finder #(
  parameter int unsigned MAX_LENGTH  = 256,
  parameter int unsigned MAX_REPORTS = 63
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lacf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lacf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  lacf_in_if.sink                             in_i,
  lacf_out_if.source                          out_o
);

  localparam int unsigned LW   = $clog2(MAX_LENGTH);
  localparam int unsigned LENW = $clog2(MAX_LENGTH + 1);
  localparam int unsigned WW   = LENW + lacf_pkg::SEP_W;
  localparam int unsigned TW   = 2 * LW;

  lacf_pkg::cfg_t   cfg_q;
  lacf_pkg::state_e state_q, state_d;

  logic [LENW-1:0] len_a_q, len_b_q;
  logic [LW-1:0]   fx_q, fy_q, cx_q, cy_q, wx_q, wy_q, tx_q, ty_q;
  logic [LW-1:0]   wx0_q;
  logic [WW-1:0]   wx1_q, wy1_q;
  logic [lacf_pkg::SCORE_W-1:0] left_q, diag_q, val_q;
  logic [lacf_pkg::CNT_W-1:0]   rpt_cnt_q;
  logic            ovf_q;

  logic            out_valid_q;
  logic            out_clone_q, out_ovf_q, out_last_q;
  logic [lacf_pkg::IDX_W-1:0]   out_as_q, out_ae_q, out_bs_q, out_be_q;
  logic [lacf_pkg::SCORE_W-1:0] out_score_q;

  // Memory ports.
  logic [LW-1:0]   sa_raddr, sb_raddr;
  logic [lacf_pkg::SYM_W-1:0] sa_rdata, sb_rdata;
  logic            sa_we, sb_we;
  logic [TW-1:0]   sc_raddr, dr_raddr, dr_waddr;
  logic [lacf_pkg::SCORE_W-1:0] sc_rdata;
  logic [lacf_pkg::DIR_W-1:0]   dr_rdata, dr_wdata;
  logic            sc_we, dr_we;

  logic [lacf_pkg::SCORE_W-1:0] up_val, left_val, diag_val, best;
  logic [1:0]      best_dir;

  logic            in_acc, out_free;
  logic            fill_x_last, fill_y_last, scan_x_last, scan_y_last;
  logic            win_x_last, win_y_last, win_fail, cand;
  logic [WW-1:0]   sep_w, cx_w, cy_w, x0_w, y0_w, x1_w, y1_w;
  logic            trace_stop;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == lacf_pkg::S_IDLE);

  // Sequence and table memories.
  lacf_ram #(.DataW(lacf_pkg::SYM_W), .AddrW(LW)) u_seq_a (
    .clk_i, .we_i(sa_we), .waddr_i(len_a_q[LW-1:0]), .wdata_i(in_i.symbol),
    .raddr_i(sa_raddr), .rdata_o(sa_rdata)
  );
  lacf_ram #(.DataW(lacf_pkg::SYM_W), .AddrW(LW)) u_seq_b (
    .clk_i, .we_i(sb_we), .waddr_i(len_b_q[LW-1:0]), .wdata_i(in_i.symbol),
    .raddr_i(sb_raddr), .rdata_o(sb_rdata)
  );
  lacf_ram #(.DataW(lacf_pkg::SCORE_W), .AddrW(TW)) u_score (
    .clk_i, .we_i(sc_we), .waddr_i({fy_q, fx_q}), .wdata_i(best),
    .raddr_i(sc_raddr), .rdata_o(sc_rdata)
  );
  lacf_ram #(.DataW(lacf_pkg::DIR_W), .AddrW(TW)) u_dir (
    .clk_i, .we_i(dr_we), .waddr_i(dr_waddr), .wdata_i(dr_wdata),
    .raddr_i(dr_raddr), .rdata_o(dr_rdata)
  );

  // Shared cell scoring unit.
  assign up_val   = (fy_q == '0) ? '0 : sc_rdata;
  assign left_val = (fx_q == '0) ? '0 : left_q;
  assign diag_val = (fx_q == '0 || fy_q == '0) ? '0 : diag_q;

  lacf_cell_unit u_cell (
    .cfg_i(cfg_q), .eq_i(sa_rdata == sb_rdata), .left_i(left_val), .up_i(up_val),
    .diag_i(diag_val), .best_o(best), .dir_o(best_dir)
  );

  // Loop bounds and window limits.
  always_comb begin
    fill_x_last = (LENW'(fx_q) + LENW'(1)) == len_a_q;
    fill_y_last = (LENW'(fy_q) + LENW'(1)) == len_b_q;
    scan_x_last = (LENW'(cx_q) + LENW'(1)) == len_a_q;
    scan_y_last = (LENW'(cy_q) + LENW'(1)) == len_b_q;
    win_x_last  = (WW'(wx_q) + WW'(1)) == wx1_q;
    win_y_last  = (WW'(wy_q) + WW'(1)) == wy1_q;
    sep_w = WW'(cfg_q.clone_separation);
    cx_w  = WW'(cx_q);
    cy_w  = WW'(cy_q);
    x0_w  = (cx_w >= sep_w) ? cx_w - sep_w : '0;
    y0_w  = (cy_w >= sep_w) ? cy_w - sep_w : '0;
    x1_w  = (cx_w + sep_w >= WW'(len_a_q)) ? WW'(len_a_q) : cx_w + sep_w;
    y1_w  = (cy_w + sep_w >= WW'(len_b_q)) ? WW'(len_b_q) : cy_w + sep_w;
    cand  = (sa_rdata == sb_rdata) && (sc_rdata >= cfg_q.min_clone_score);
    win_fail = !(wx_q == cx_q && wy_q == cy_q) &&
               (dr_rdata[2] || sc_rdata > val_q);
    case (dr_rdata[1:0])
      lacf_pkg::DIR_LEFT: trace_stop = (tx_q == '0);
      lacf_pkg::DIR_UP:   trace_stop = (ty_q == '0);
      lacf_pkg::DIR_DIAG: trace_stop = (tx_q == '0 || ty_q == '0);
      default:            trace_stop = 1'b1;
    endcase
  end

  // Memory address and write selection.
  always_comb begin
    sa_we    = in_acc && in_i.operation == lacf_pkg::OP_APPEND_A &&
               len_a_q < LENW'(MAX_LENGTH);
    sb_we    = in_acc && in_i.operation == lacf_pkg::OP_APPEND_B &&
               len_b_q < LENW'(MAX_LENGTH);
    sa_raddr = cx_q;
    sb_raddr = cy_q;
    sc_raddr = {cy_q, cx_q};
    dr_raddr = {wy_q, wx_q};
    sc_we    = 1'b0;
    dr_we    = 1'b0;
    dr_waddr = {fy_q, fx_q};
    dr_wdata = {1'b0, best_dir};
    case (state_q)
      lacf_pkg::S_FILL_RD: begin
        sa_raddr = fx_q;
        sb_raddr = fy_q;
        sc_raddr = {fy_q - LW'(1), fx_q};
      end
      lacf_pkg::S_FILL_CALC: begin
        sc_we = 1'b1;
        dr_we = 1'b1;
      end
      lacf_pkg::S_WIN_RD: begin
        sc_raddr = {wy_q, wx_q};
      end
      lacf_pkg::S_TRACE_RD: begin
        dr_raddr = {ty_q, tx_q};
      end
      lacf_pkg::S_TRACE_STEP: begin
        dr_we    = 1'b1;
        dr_waddr = {ty_q, tx_q};
        dr_wdata = dr_rdata | 3'b100;
      end
      default: ;
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lacf_pkg::S_IDLE: begin
        if (in_acc && in_i.operation == lacf_pkg::OP_RUN) begin
          state_d = (len_a_q == '0 || len_b_q == '0) ? lacf_pkg::S_FINAL
                                                     : lacf_pkg::S_FILL_RD;
        end
      end
      lacf_pkg::S_FILL_RD:   state_d = lacf_pkg::S_FILL_CALC;
      lacf_pkg::S_FILL_CALC: begin
        state_d = (fill_x_last && fill_y_last) ? lacf_pkg::S_SCAN_RD : lacf_pkg::S_FILL_RD;
      end
      lacf_pkg::S_SCAN_RD:   state_d = lacf_pkg::S_SCAN_CHK;
      lacf_pkg::S_SCAN_CHK: begin
        if (cand) begin
          state_d = (cfg_q.clone_separation == '0) ? lacf_pkg::S_TRACE_RD
                                                   : lacf_pkg::S_WIN_RD;
        end else begin
          state_d = (scan_x_last && scan_y_last) ? lacf_pkg::S_FINAL : lacf_pkg::S_SCAN_RD;
        end
      end
      lacf_pkg::S_WIN_RD:    state_d = lacf_pkg::S_WIN_CHK;
      lacf_pkg::S_WIN_CHK: begin
        if (win_fail) begin
          state_d = (scan_x_last && scan_y_last) ? lacf_pkg::S_FINAL : lacf_pkg::S_SCAN_RD;
        end else if (win_x_last && win_y_last) begin
          state_d = lacf_pkg::S_TRACE_RD;
        end else begin
          state_d = lacf_pkg::S_WIN_RD;
        end
      end
      lacf_pkg::S_TRACE_RD:  state_d = lacf_pkg::S_TRACE_STEP;
      lacf_pkg::S_TRACE_STEP: begin
        state_d = trace_stop ? lacf_pkg::S_REPORT : lacf_pkg::S_TRACE_RD;
      end
      lacf_pkg::S_REPORT: begin
        if (rpt_cnt_q >= lacf_pkg::CNT_W'(MAX_REPORTS) || out_free) begin
          state_d = (scan_x_last && scan_y_last) ? lacf_pkg::S_FINAL : lacf_pkg::S_SCAN_RD;
        end
      end
      lacf_pkg::S_FINAL: begin
        if (out_free) begin
          state_d = lacf_pkg::S_IDLE;
        end
      end
      default: state_d = lacf_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lacf_pkg::S_IDLE;
      cfg_q     <= '{lacf_pkg::RST_MATCH, lacf_pkg::RST_MISMATCH, lacf_pkg::RST_GAP,
                     lacf_pkg::RST_MIN, lacf_pkg::RST_SEP};
      len_a_q   <= '0;
      len_b_q   <= '0;
      rpt_cnt_q <= '0;
      ovf_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lacf_pkg::REG_MATCH:    cfg_q.match_score      <= cfg_data_i[lacf_pkg::PEN_W-1:0];
          lacf_pkg::REG_MISMATCH: cfg_q.mismatch_penalty <= cfg_data_i[lacf_pkg::PEN_W-1:0];
          lacf_pkg::REG_GAP:      cfg_q.gap_penalty      <= cfg_data_i[lacf_pkg::PEN_W-1:0];
          lacf_pkg::REG_MIN:      cfg_q.min_clone_score  <= cfg_data_i;
          lacf_pkg::REG_SEP:      cfg_q.clone_separation <= cfg_data_i[lacf_pkg::SEP_W-1:0];
          default: ;
        endcase
      end
      if (sa_we) len_a_q <= len_a_q + LENW'(1);
      if (sb_we) len_b_q <= len_b_q + LENW'(1);
      if (in_acc && in_i.operation == lacf_pkg::OP_RUN) begin
        rpt_cnt_q <= '0;
        ovf_q     <= 1'b0;
      end
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      if (state_q == lacf_pkg::S_REPORT) begin
        if (rpt_cnt_q >= lacf_pkg::CNT_W'(MAX_REPORTS)) begin
          ovf_q <= 1'b1;
        end else if (out_free) begin
          out_valid_q <= 1'b1;
          rpt_cnt_q   <= rpt_cnt_q + lacf_pkg::CNT_W'(1);
        end
      end
      if (state_q == lacf_pkg::S_FINAL && out_free) begin
        out_valid_q <= 1'b1;
        len_a_q     <= '0;
        len_b_q     <= '0;
      end
    end
  end

  // Loop counters and working values.
  always_ff @(posedge clk_i) begin
    case (state_q)
      lacf_pkg::S_IDLE: begin
        fx_q <= '0;
        fy_q <= '0;
        cx_q <= '0;
        cy_q <= '0;
      end
      lacf_pkg::S_FILL_CALC: begin
        left_q <= best;
        diag_q <= up_val;
        if (fill_x_last) begin
          fx_q <= '0;
          fy_q <= fy_q + LW'(1);
        end else begin
          fx_q <= fx_q + LW'(1);
        end
      end
      lacf_pkg::S_SCAN_CHK: begin
        val_q <= sc_rdata;
        wx0_q <= x0_w[LW-1:0];
        wx_q  <= x0_w[LW-1:0];
        wy_q  <= y0_w[LW-1:0];
        wx1_q <= x1_w;
        wy1_q <= y1_w;
        tx_q  <= cx_q;
        ty_q  <= cy_q;
      end
      lacf_pkg::S_WIN_CHK: begin
        if (win_x_last) begin
          wx_q <= wx0_q;
          wy_q <= wy_q + LW'(1);
        end else begin
          wx_q <= wx_q + LW'(1);
        end
      end
      lacf_pkg::S_TRACE_STEP: begin
        if (!trace_stop) begin
          if (dr_rdata[1:0] != lacf_pkg::DIR_UP) tx_q <= tx_q - LW'(1);
          if (dr_rdata[1:0] != lacf_pkg::DIR_LEFT) ty_q <= ty_q - LW'(1);
        end
      end
      default: ;
    endcase
    // Step to the next scanned cell.
    if ((state_q == lacf_pkg::S_SCAN_CHK && !cand) ||
        (state_q == lacf_pkg::S_WIN_CHK && win_fail) ||
        (state_q == lacf_pkg::S_REPORT && state_d != lacf_pkg::S_REPORT)) begin
      if (scan_x_last) begin
        cx_q <= '0;
        cy_q <= cy_q + LW'(1);
      end else begin
        cx_q <= cx_q + LW'(1);
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (state_q == lacf_pkg::S_REPORT && out_free &&
        rpt_cnt_q < lacf_pkg::CNT_W'(MAX_REPORTS)) begin
      out_clone_q <= 1'b1;
      out_as_q    <= lacf_pkg::IDX_W'(tx_q);
      out_ae_q    <= lacf_pkg::IDX_W'(cx_q);
      out_bs_q    <= lacf_pkg::IDX_W'(ty_q);
      out_be_q    <= lacf_pkg::IDX_W'(cy_q);
      out_score_q <= val_q;
      out_ovf_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (state_q == lacf_pkg::S_FINAL && out_free) begin
      out_clone_q <= 1'b0;
      out_as_q    <= '0;
      out_ae_q    <= '0;
      out_bs_q    <= '0;
      out_be_q    <= '0;
      out_score_q <= '0;
      out_ovf_q   <= ovf_q;
      out_last_q  <= 1'b1;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.is_clone = out_clone_q;
  assign out_o.a_start  = out_as_q;
  assign out_o.a_end    = out_ae_q;
  assign out_o.b_start  = out_bs_q;
  assign out_o.b_end    = out_be_q;
  assign out_o.score    = out_score_q;
  assign out_o.overflow = out_ovf_q;
  assign out_o.last     = out_last_q;

  // Checks on the sequencer and the result register.
  `LACF_ASSERT_NXT(a_run_holds, in_acc && in_i.operation == lacf_pkg::OP_RUN, !in_i.ready, "input ready right after a run item")
  `LACF_ASSERT_IMP(a_cnt_cap, 1'b1, rpt_cnt_q <= lacf_pkg::CNT_W'(MAX_REPORTS), "report count beyond cap")
  `LACF_ASSERT_IMP(a_last_clean, out_valid_q && out_last_q, !out_clone_q && out_score_q == '0, "completion record carries clone data")
  `LACF_ASSERT_IMP(a_clone_min, out_valid_q && out_clone_q, out_score_q >= cfg_q.min_clone_score && !out_last_q, "clone report below threshold")

endmodule

FILE: rtl/lacf_ram.sv
module lacf_ram #(
  parameter int unsigned DataW = 14,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [2**AddrW];
  logic [DataW-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lacf_cell_unit.sv
module lacf_cell_unit (
  input  lacf_pkg::cfg_t                 cfg_i,
  input  logic                           eq_i,
  input  logic [lacf_pkg::SCORE_W-1:0]   left_i,
  input  logic [lacf_pkg::SCORE_W-1:0]   up_i,
  input  logic [lacf_pkg::SCORE_W-1:0]   diag_i,
  output logic [lacf_pkg::SCORE_W-1:0]   best_o,
  output logic [1:0]                     dir_o
);

  logic signed [15:0] diag_s, left_s, up_s, best_s;

  // Candidate scores of the three moves.
  always_comb begin
    diag_s = eq_i ? $signed(16'(diag_i)) + $signed(16'(cfg_i.match_score))
                  : $signed(16'(diag_i)) - $signed(16'(cfg_i.mismatch_penalty));
    left_s = $signed(16'(left_i)) - $signed(16'(cfg_i.gap_penalty));
    up_s   = $signed(16'(up_i)) - $signed(16'(cfg_i.gap_penalty));
  end

  // Floor at zero; diagonal wins ties over left, left over up.
  always_comb begin
    best_s = '0;
    dir_o  = lacf_pkg::DIR_END;
    if (diag_s > best_s) begin
      best_s = diag_s;
      dir_o  = lacf_pkg::DIR_DIAG;
    end
    if (left_s > best_s) begin
      best_s = left_s;
      dir_o  = lacf_pkg::DIR_LEFT;
    end
    if (up_s > best_s) begin
      best_s = up_s;
      dir_o  = lacf_pkg::DIR_UP;
    end
    if (best_s > $signed(16'(lacf_pkg::SCORE_MAX))) begin
      best_o = lacf_pkg::SCORE_MAX;
    end else begin
      best_o = best_s[lacf_pkg::SCORE_W-1:0];
    end
  end

endmodule
